### rtl/bnb_pkg.sv
// Shared types and constants for the naive Bayes classifier.
package bnb_pkg;

  // Fixed field widths of the channels and the result queue depth
  localparam int MODE_W     = 2;
  localparam int CLASS_FW   = 4;
  localparam int PIXEL_FW   = 10;
  localparam int SCORE_W    = 34;
  localparam int RESULT_DEPTH = 4;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Beat operation codes; the spare code does nothing
  typedef enum logic [MODE_W-1:0] {
    MODE_PRIOR = 2'd0,
    MODE_PAIR  = 2'd1,
    MODE_PIXEL = 2'd2
  } mode_t;

  // Control that follows a pixel beat through the score stage
  typedef struct packed {
    logic valid;
    logic first;
    logic add;
    logic white;
    logic last;
  } pix_ctl_t;

  // One queued result
  typedef struct packed {
    logic [CLASS_FW-1:0] predicted_class;
    score_t              best_score;
  } result_t;

endpackage

### rtl/bnb_in_if.sv
// Input channel: table loads and classified pixels.
interface bnb_in_if #(
  parameter int LOG_BITS = 24
);
  logic                              valid;
  logic                              ready;
  logic [bnb_pkg::MODE_W-1:0]        mode;
  logic [bnb_pkg::CLASS_FW-1:0]      class_index;
  logic [bnb_pkg::PIXEL_FW-1:0]      pixel_index;
  logic signed [LOG_BITS-1:0]        log_value_white;
  logic signed [LOG_BITS-1:0]        log_value_black;
  logic                              pixel_white;
  logic                              last_pixel;

  modport source (
    output valid, mode, class_index, pixel_index, log_value_white, log_value_black,
           pixel_white, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, mode, class_index, pixel_index, log_value_white, log_value_black,
           pixel_white, last_pixel,
    output ready
  );
endinterface

### rtl/bnb_out_if.sv
// Output channel: predicted class and its score.
interface bnb_out_if;
  logic                          valid;
  logic                          ready;
  logic [bnb_pkg::CLASS_FW-1:0]  predicted_class;
  logic signed [bnb_pkg::SCORE_W-1:0] best_score;

  modport source (output valid, predicted_class, best_score, input ready);
  modport sink (input valid, predicted_class, best_score, output ready);
endinterface

### rtl/bnb_log_bank.sv
// Per-class log table: white and black terms of every pixel position.
module bnb_log_bank #(
  parameter int NUM_PIXEL = 784,
  parameter int LOG_BITS  = 24,
  parameter int PIX_W     = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [PIX_W-1:0]           wr_addr,
  input  logic signed [LOG_BITS-1:0] wr_white,
  input  logic signed [LOG_BITS-1:0] wr_black,
  input  logic                       rd_en,
  input  logic [PIX_W-1:0]           rd_addr,
  output logic signed [LOG_BITS-1:0] rd_white,
  output logic signed [LOG_BITS-1:0] rd_black
);

  logic [2*LOG_BITS-1:0] mem [NUM_PIXEL];
  logic [2*LOG_BITS-1:0] rd_data;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_white, wr_black};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_white = rd_data[2*LOG_BITS-1:LOG_BITS];
  assign rd_black = rd_data[LOG_BITS-1:0];

endmodule

### rtl/bnb_score_unit.sv
// Log priors and running class scores, all classes updated in parallel.
module bnb_score_unit #(
  parameter int NUM_CLASS = 10,
  parameter int LOG_BITS  = 24,
  parameter int CLS_W     = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       prior_wr,
  input  logic [CLS_W-1:0]           prior_idx,
  input  logic signed [LOG_BITS-1:0] prior_val,
  input  bnb_pkg::pix_ctl_t          ctl,
  input  logic signed [LOG_BITS-1:0] term_white [NUM_CLASS],
  input  logic signed [LOG_BITS-1:0] term_black [NUM_CLASS],
  output bnb_pkg::score_t            class_scores [NUM_CLASS],
  output logic                       done
);

  localparam int SUM_W = bnb_pkg::SCORE_W + 1;

  logic signed [LOG_BITS-1:0] prior_log [NUM_CLASS];
  bnb_pkg::score_t            class_scores_next [NUM_CLASS];

  // Prior table, one register per class
  always_ff @(posedge clk) begin
    if (prior_wr) begin
      prior_log[prior_idx] <= prior_val;
    end
  end

  // Saturating add of the selected term to each score (the prior on a first pixel), if add is set
  always_comb begin
    bnb_pkg::score_t            base;
    logic signed [LOG_BITS-1:0] term;
    logic signed [SUM_W-1:0]    sum;
    for (int c = 0; c < NUM_CLASS; c++) begin
      base = ctl.first ? bnb_pkg::score_t'(prior_log[c]) : class_scores[c];
      term = ctl.white ? term_white[c] : term_black[c];
      sum  = SUM_W'(base) + SUM_W'(term);
      if (!ctl.add) begin
        class_scores_next[c] = base;
      end else if (sum[SUM_W-1] != sum[SUM_W-2]) begin
        class_scores_next[c] = sum[SUM_W-1] ? bnb_pkg::SCORE_MIN : bnb_pkg::SCORE_MAX;
      end else begin
        class_scores_next[c] = sum[SUM_W-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        class_scores[c] <= '0;
      end
      done <= 1'b0;
    end else begin
      if (ctl.valid) begin
        class_scores <= class_scores_next;
      end
      done <= ctl.valid & ctl.last;
    end
  end

endmodule

### rtl/bnb_argmax.sv
// Comparison tree picking the highest score, lower class on ties.
module bnb_argmax #(
  parameter int NUM_CLASS = 10,
  parameter int CLS_W     = 4
) (
  input  bnb_pkg::score_t            class_scores [NUM_CLASS],
  output bnb_pkg::result_t           result
);

  localparam int LEVELS = $clog2(NUM_CLASS);

  bnb_pkg::score_t  cand_score [NUM_CLASS];
  logic [CLS_W-1:0] cand_idx   [NUM_CLASS];

  // Each level folds the right half of a pair into its left node
  always_comb begin
    for (int c = 0; c < NUM_CLASS; c++) begin
      cand_score[c] = class_scores[c];
      cand_idx[c]   = CLS_W'(c);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        if (((c & ((2 << l) - 1)) == 0) && (c + (1 << l) < NUM_CLASS)) begin
          if (cand_score[c + (1 << l)] > cand_score[c]) begin
            cand_score[c] = cand_score[c + (1 << l)];
            cand_idx[c]   = cand_idx[c + (1 << l)];
          end
        end
      end
    end
    result.predicted_class = bnb_pkg::CLASS_FW'(cand_idx[0]);
    result.best_score      = cand_score[0];
  end

endmodule

### rtl/bnb_result_fifo.sv
// Small result queue that decouples the output from the pipeline.
module bnb_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bnb_pkg::result_t push_data,
  bnb_out_if.source        result,
  output logic [$clog2(bnb_pkg::RESULT_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(bnb_pkg::RESULT_DEPTH);

  bnb_pkg::result_t mem [bnb_pkg::RESULT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign pop                    = result.valid & result.ready;
  assign result.valid           = count != '0;
  assign result.predicted_class = mem[rd_ptr].predicted_class;
  assign result.best_score      = mem[rd_ptr].best_score;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/binary_naive_bayes_classifier.sv
// Top level of the Bernoulli naive Bayes image classifier.
//
// pixel_in carries one beat per operation: mode 0 loads a class log prior,
// mode 1 loads the white/black log pair of one class and pixel, mode 2
// classifies the next pixel of the image. Loads outside the table are dropped.
// result carries one beat per image, after the pixel beat marked last.
// One beat is taken per cycle while pixel_in.ready is high. A pixel reads all
// class banks at once (one memory read port per class), the scores update in
// the next cycle and the comparison tree writes the result queue in the cycle
// after that. If the receiver stalls, results wait in a four-entry queue;
// pixel_in.ready drops only once the queue plus results still in the pipeline
// would fill it. Reset clears the image state, scores and queue; the log
// tables keep whatever they hold and must be loaded before use.
module binary_naive_bayes_classifier #(
  parameter int NUM_CLASS = 10,
  parameter int NUM_PIXEL = 784,
  parameter int LOG_BITS  = 24
) (
  input logic        clk,
  input logic        rst,
  bnb_in_if.sink     pixel_in,
  bnb_out_if.source  result
);

  localparam int CLS_W = $clog2(NUM_CLASS);
  localparam int PIX_W = (NUM_PIXEL > 1) ? $clog2(NUM_PIXEL) : 1;
  localparam int CNT_W = $clog2(NUM_PIXEL + 1);
  localparam int FILL_W = $clog2(bnb_pkg::RESULT_DEPTH + 1);

  logic                       accept;
  logic                       is_prior;
  logic                       is_pair;
  logic                       is_pixel;
  logic                       class_ok;
  logic                       pixel_ok;
  logic                       image_in_progress;
  logic [CNT_W-1:0]           pixel_pos;
  logic                       pos_add;
  bnb_pkg::pix_ctl_t          ctl;
  logic signed [LOG_BITS-1:0] term_white [NUM_CLASS];
  logic signed [LOG_BITS-1:0] term_black [NUM_CLASS];
  bnb_pkg::score_t            class_scores [NUM_CLASS];
  logic                       done;
  bnb_pkg::result_t           best;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W:0]            committed;

  // Beat decode
  assign accept   = pixel_in.valid & pixel_in.ready;
  assign class_ok = 32'(pixel_in.class_index) < NUM_CLASS;
  assign pixel_ok = 32'(pixel_in.pixel_index) < NUM_PIXEL;
  assign pos_add  = 32'(pixel_pos) < NUM_PIXEL;

  always_comb begin
    is_prior = 1'b0;
    is_pair  = 1'b0;
    is_pixel = 1'b0;
    case (pixel_in.mode)
      bnb_pkg::MODE_PRIOR: is_prior = 1'b1;
      bnb_pkg::MODE_PAIR:  is_pair  = 1'b1;
      bnb_pkg::MODE_PIXEL: is_pixel = 1'b1;
      default: ;
    endcase
  end

  // Hold off beats while queued plus in-flight results could overrun the queue
  assign committed      = (FILL_W + 1)'(fill) + (FILL_W + 1)'(ctl.valid & ctl.last)
                          + (FILL_W + 1)'(done);
  assign pixel_in.ready = committed < (FILL_W + 1)'(bnb_pkg::RESULT_DEPTH);

  // Image position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      image_in_progress <= 1'b0;
      pixel_pos         <= '0;
    end else if (accept && is_pixel) begin
      if (pixel_in.last_pixel) begin
        image_in_progress <= 1'b0;
        pixel_pos         <= '0;
      end else begin
        image_in_progress <= 1'b1;
        pixel_pos         <= pixel_pos + CNT_W'(pos_add);
      end
    end
  end

  // Pixel control into the score stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= accept & is_pixel;
    end
    ctl.first <= ~image_in_progress;
    ctl.add   <= pos_add;
    ctl.white <= pixel_in.pixel_white;
    ctl.last  <= pixel_in.last_pixel;
  end

  // One table bank per class
  for (genvar c = 0; c < NUM_CLASS; c++) begin : g_bank
    bnb_log_bank #(
      .NUM_PIXEL (NUM_PIXEL),
      .LOG_BITS  (LOG_BITS),
      .PIX_W     (PIX_W)
    ) u_bank (
      .clk      (clk),
      .wr_en    (accept && is_pair && class_ok && pixel_ok &&
                 (32'(pixel_in.class_index) == c)),
      .wr_addr  (PIX_W'(pixel_in.pixel_index)),
      .wr_white (pixel_in.log_value_white),
      .wr_black (pixel_in.log_value_black),
      .rd_en    (accept & is_pixel),
      .rd_addr  (pixel_pos[PIX_W-1:0]),
      .rd_white (term_white[c]),
      .rd_black (term_black[c])
    );
  end

  bnb_score_unit #(
    .NUM_CLASS (NUM_CLASS),
    .LOG_BITS  (LOG_BITS),
    .CLS_W     (CLS_W)
  ) u_score (
    .clk          (clk),
    .rst          (rst),
    .prior_wr     (accept & is_prior & class_ok),
    .prior_idx    (CLS_W'(pixel_in.class_index)),
    .prior_val    (pixel_in.log_value_white),
    .ctl          (ctl),
    .term_white   (term_white),
    .term_black   (term_black),
    .class_scores (class_scores),
    .done         (done)
  );

  bnb_argmax #(
    .NUM_CLASS (NUM_CLASS),
    .CLS_W     (CLS_W)
  ) u_argmax (
    .class_scores (class_scores),
    .result       (best)
  );

  bnb_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (done),
    .push_data (best),
    .result    (result),
    .count     (fill)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the Bernoulli naive Bayes image classifier.
module tb;

  localparam int NUM_CLASS = 10;
  localparam int NUM_PIXEL = 784;
  localparam int LOG_BITS  = 24;
  // pixel positions whose pairs are loaded for every class
  localparam int LOADED_PIXELS = 32;

  localparam logic [bnb_pkg::MODE_W-1:0]  MODE_SPARE = 2'd3;
  localparam logic signed [LOG_BITS-1:0] MAX_LOG    = {1'b0, {(LOG_BITS-1){1'b1}}};
  localparam logic signed [LOG_BITS-1:0] MIN_LOG    = {1'b1, {(LOG_BITS-1){1'b0}}};

  typedef logic signed [LOG_BITS-1:0] log_t;

  // One input beat as the sender sees it
  typedef struct {
    logic [bnb_pkg::MODE_W-1:0]   mode;
    logic [bnb_pkg::CLASS_FW-1:0] class_index;
    logic [bnb_pkg::PIXEL_FW-1:0] pixel_index;
    log_t                         log_white;
    log_t                         log_black;
    logic                         pixel_white;
    logic                         last_pixel;
  } beat_t;

  logic clk;
  logic rst;

  bnb_in_if #(.LOG_BITS(LOG_BITS)) in_ch ();
  bnb_out_if                       out_ch ();

  binary_naive_bayes_classifier #(
    .NUM_CLASS (NUM_CLASS),
    .NUM_PIXEL (NUM_PIXEL),
    .LOG_BITS  (LOG_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (in_ch),
    .result   (out_ch)
  );

  // Classifier state as the testbench tracks it
  log_t            white_tab [NUM_CLASS*NUM_PIXEL];
  log_t            black_tab [NUM_CLASS*NUM_PIXEL];
  log_t            prior_tab [NUM_CLASS];
  bnb_pkg::score_t class_score [NUM_CLASS];
  bit              image_open;
  int unsigned     next_pos;

  bnb_pkg::result_t expected_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_beats;
  int n_images;
  int n_results;
  int n_errors;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  // Receiver readiness, redrawn every cycle
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // Score addition saturating to the signed score range
  function automatic bnb_pkg::score_t add_sat(input bnb_pkg::score_t a, input log_t t);
    logic signed [bnb_pkg::SCORE_W:0] s;
    s = (bnb_pkg::SCORE_W+1)'(a) + (bnb_pkg::SCORE_W+1)'(t);
    if (s > bnb_pkg::SCORE_MAX) return bnb_pkg::SCORE_MAX;
    if (s < bnb_pkg::SCORE_MIN) return bnb_pkg::SCORE_MIN;
    return s[bnb_pkg::SCORE_W-1:0];
  endfunction

  // Apply one accepted beat to the tracked state; queue a result on a last pixel
  function automatic void score_beat(input beat_t b);
    int               addr;
    int               best;
    log_t             term;
    bnb_pkg::result_t r;
    case (b.mode)
      bnb_pkg::MODE_PRIOR: begin
        if (b.class_index < NUM_CLASS) prior_tab[b.class_index] = b.log_white;
      end
      bnb_pkg::MODE_PAIR: begin
        if (b.class_index < NUM_CLASS && b.pixel_index < NUM_PIXEL) begin
          addr = b.class_index * NUM_PIXEL + b.pixel_index;
          white_tab[addr] = b.log_white;
          black_tab[addr] = b.log_black;
        end
      end
      bnb_pkg::MODE_PIXEL: begin
        if (!image_open) begin
          for (int c = 0; c < NUM_CLASS; c++) class_score[c] = bnb_pkg::score_t'(prior_tab[c]);
          next_pos   = 0;
          image_open = 1'b1;
        end
        // past the end of the image the scores hold
        if (next_pos < NUM_PIXEL) begin
          for (int c = 0; c < NUM_CLASS; c++) begin
            addr = c * NUM_PIXEL + next_pos;
            term = b.pixel_white ? white_tab[addr] : black_tab[addr];
            class_score[c] = add_sat(class_score[c], term);
          end
          next_pos++;
        end
        if (b.last_pixel) begin
          // strict compare keeps the lowest class on a tie
          best = 0;
          for (int c = 1; c < NUM_CLASS; c++)
            if (class_score[c] > class_score[best]) best = c;
          r.predicted_class = best[bnb_pkg::CLASS_FW-1:0];
          r.best_score      = class_score[best];
          expected_results  = {expected_results, r};
          image_open = 1'b0;
          next_pos   = 0;
          n_images++;
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one beat at the falling edge and hold it until accepted
  task automatic send_beat(input beat_t b);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode            = b.mode;
    in_ch.class_index     = b.class_index;
    in_ch.pixel_index     = b.pixel_index;
    in_ch.log_value_white = b.log_white;
    in_ch.log_value_black = b.log_black;
    in_ch.pixel_white     = b.pixel_white;
    in_ch.last_pixel      = b.last_pixel;
    in_ch.valid           = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    score_beat(b);
    n_beats++;
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    bnb_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result class %0d score %0d",
                                  out_ch.predicted_class, out_ch.best_score));
      end else begin
        want = expected_results.pop_front();
        n_results++;
        if (out_ch.predicted_class !== want.predicted_class)
          report_mismatch($sformatf("class %0d, expected %0d",
                                    out_ch.predicted_class, want.predicted_class));
        if (out_ch.best_score !== want.best_score)
          report_mismatch($sformatf("score %0d, expected %0d",
                                    out_ch.best_score, want.best_score));
      end
    end
  end

  // Log values: extremes and edge codes often, otherwise the full 24-bit range
  function automatic log_t rand_log();
    case ($urandom_range(7))
      0: return MIN_LOG;
      1: return MAX_LOG;
      2: return '0;
      3: return '1;
      default: return log_t'($urandom);
    endcase
  endfunction

  // Beat in the spare mode with every other field random; callers overwrite what matters
  function automatic beat_t noise_beat();
    beat_t b;
    b.mode        = MODE_SPARE;
    b.class_index = bnb_pkg::CLASS_FW'($urandom);
    b.pixel_index = bnb_pkg::PIXEL_FW'($urandom);
    b.log_white   = log_t'($urandom);
    b.log_black   = log_t'($urandom);
    b.pixel_white = 1'($urandom);
    b.last_pixel  = 1'($urandom);
    return b;
  endfunction

  task automatic load_prior(input logic [bnb_pkg::CLASS_FW-1:0] cls, input log_t v);
    beat_t b;
    b             = noise_beat();
    b.mode        = bnb_pkg::MODE_PRIOR;
    b.class_index = cls;
    b.log_white   = v;
    send_beat(b);
  endtask

  task automatic load_pair(input logic [bnb_pkg::CLASS_FW-1:0] cls,
                           input logic [bnb_pkg::PIXEL_FW-1:0] pix,
                           input log_t w, input log_t k);
    beat_t b;
    b             = noise_beat();
    b.mode        = bnb_pkg::MODE_PAIR;
    b.class_index = cls;
    b.pixel_index = pix;
    b.log_white   = w;
    b.log_black   = k;
    send_beat(b);
  endtask

  task automatic send_pixel(input logic white, input logic last);
    beat_t b;
    b             = noise_beat();
    b.mode        = bnb_pkg::MODE_PIXEL;
    b.pixel_white = white;
    b.last_pixel  = last;
    send_beat(b);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Load every class prior and fill the leading pixel positions of every class; images never go past them
  task automatic test_table_load();
    for (int c = 0; c < NUM_CLASS; c++) load_prior(bnb_pkg::CLASS_FW'(c), rand_log());
    for (int c = 0; c < NUM_CLASS; c++)
      for (int p = 0; p < LOADED_PIXELS; p++)
        load_pair(bnb_pkg::CLASS_FW'(c), bnb_pkg::PIXEL_FW'(p), rand_log(), rand_log());
  endtask

  // Spare mode, dropped loads, ties, single-pixel images, loads mid-image
  task automatic test_directed();
    send_beat(noise_beat());
    load_prior(4'd15, MAX_LOG);
    load_pair(4'd10, 10'd5, MAX_LOG, MAX_LOG);
    load_pair(4'd3, 10'd1023, MAX_LOG, MAX_LOG);
    load_pair(4'd15, 10'd1023, MIN_LOG, MIN_LOG);
    load_prior(4'd0, MIN_LOG);
    load_pair(bnb_pkg::CLASS_FW'(NUM_CLASS-1), bnb_pkg::PIXEL_FW'(NUM_PIXEL-1),
              MAX_LOG, MIN_LOG);
    // classes 2 and 6 tie at the top; the lower one must win
    load_prior(4'd2, MAX_LOG);
    load_prior(4'd6, MAX_LOG);
    load_pair(4'd2, 10'd0, MAX_LOG, MIN_LOG);
    load_pair(4'd6, 10'd0, MAX_LOG, MIN_LOG);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);
    // table rewritten while the image is in flight
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    load_pair(4'd0, 10'd2, MAX_LOG, MAX_LOG);
    send_pixel(1'b1, 1'b1);
  endtask

  // Image that covers every loaded pixel position
  task automatic test_long_images();
    for (int p = 0; p < LOADED_PIXELS; p++) send_pixel(1'($urandom), p == LOADED_PIXELS-1);
  endtask

  // Mostly short images with random pixels, interleaved with loads and noise
  task automatic run_random_phase(input int n_useful);
    beat_t b;
    int    done;
    int    remaining;
    int    r;
    done      = 0;
    remaining = 0;
    while (done < n_useful || remaining != 0) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_beat(noise_beat());
      end else if (r < 22) begin
        b             = noise_beat();
        b.mode        = $urandom_range(1) ? bnb_pkg::MODE_PAIR : bnb_pkg::MODE_PRIOR;
        b.class_index = bnb_pkg::CLASS_FW'(($urandom_range(7) == 0) ? $urandom_range(15)
                                                                    : $urandom_range(9));
        b.pixel_index = bnb_pkg::PIXEL_FW'(($urandom_range(7) == 0) ? $urandom_range(1023)
                                                                    : $urandom_range(783));
        b.log_white   = rand_log();
        b.log_black   = rand_log();
        send_beat(b);
        if (b.class_index < NUM_CLASS &&
            (b.mode == bnb_pkg::MODE_PRIOR || b.pixel_index < NUM_PIXEL))
          done++;
      end else begin
        if (remaining == 0)
          remaining = $urandom_range(1, 24);
        send_pixel(1'($urandom), remaining == 1);
        remaining--;
        done++;
      end
    end
  endtask

  task automatic test_random();
    set_idling(0, 0);
    run_random_phase(400);
    set_idling(56, 0);
    run_random_phase(400);
    set_idling(0, 56);
    run_random_phase(400);
    set_idling(28, 28);
    run_random_phase(400);
  endtask

  // Sequence
  initial begin
    rst                   = 1'b1;
    in_ch.valid           = 1'b0;
    in_ch.mode            = bnb_pkg::MODE_PRIOR;
    in_ch.class_index     = '0;
    in_ch.pixel_index     = '0;
    in_ch.log_value_white = '0;
    in_ch.log_value_black = '0;
    in_ch.pixel_white     = 1'b0;
    in_ch.last_pixel      = 1'b0;
    image_open            = 1'b0;
    next_pos              = 0;
    n_beats               = 0;
    n_images              = 0;
    n_results             = 0;
    n_errors              = 0;
    for (int c = 0; c < NUM_CLASS; c++) class_score[c] = '0;
    set_idling(0, 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_table_load();
    test_directed();
    test_long_images();
    test_random();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d beats sent (partial table load, directed, span and random images)",
             n_beats);
    $display("tb: %0d images classified, %0d results checked, %0d mismatches",
             n_images, n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bnb_pkg.sv
rtl/bnb_in_if.sv
rtl/bnb_out_if.sv
rtl/bnb_log_bank.sv
rtl/bnb_score_unit.sv
rtl/bnb_argmax.sv
rtl/bnb_result_fifo.sv
rtl/binary_naive_bayes_classifier.sv
tb/sv/tb.sv
